// ----- rtl/assert_macros.svh -----
// Assertion macros used by the servo sequencer checker.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define MSSP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check a property on every rising edge, reset included.
`define MSSP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/mssp_pkg.sv -----
// Package for the multiplexed servo pulse sequencer: widths, reset values,
// register indexes and the position-to-width function. No dependencies.
`default_nettype none

package mssp_pkg;

	localparam int CHANNELS   = 8;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W      = $clog2(CHANNELS + 1);
	localparam int CMP_W      = 5;

	localparam int FRAME_W    = 11;
	localparam int POS_W      = 8;
	localparam int WIDTH_W    = 7;
	localparam int PULSE_W    = 8;
	localparam int CCNT_W     = 4;
	localparam int SEL_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [FRAME_W-1:0] FRAME_PERIOD_RST = FRAME_W'(1250);
	localparam logic [CCNT_W-1:0]  CHANNEL_COUNT_RST = '0;
	localparam logic [POS_W-1:0]   POS_RST   = POS_W'(128);
	localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(94);

	localparam int WIDTH_BASE  = 63;
	localparam int WIDTH_SCALE = 63;
	localparam int PROD_W      = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_PERIOD  = 2'd0,
		REG_CHANNEL_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_SET  = 1'b1
	} item_mode_t;

	// Pulse width 63 + floor(63*pos/255); x/255 done as (x + (x>>8) + 1) >> 8,
	// exact for every x below 65535.
	function automatic logic [WIDTH_W-1:0] pulse_width(input logic [POS_W-1:0] pos);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] sum;
		prod = PROD_W'(pos) * PROD_W'(WIDTH_SCALE);
		sum  = prod + (prod >> 8) + PROD_W'(1);
		return WIDTH_W'(WIDTH_BASE) + WIDTH_W'(sum >> 8);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mssp_ifs.sv -----
// Channel interfaces of the servo sequencer: item stream, result stream and
// configuration write port. Depends on mssp_pkg.
`default_nettype none

interface mssp_item_if import mssp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [SEL_W-1:0]   channel;
	logic [POS_W-1:0]   position;

	modport source (output valid, output mode, output channel, output position, input ready);
	modport sink   (input valid, input mode, input channel, input position, output ready);
endinterface

interface mssp_result_if import mssp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] channel_pulses;
	logic [POS_W-1:0]   read_position;
	logic               frame_start;

	modport source (output valid, output channel_pulses, output read_position,
		output frame_start, input ready);
	modport sink   (input valid, input channel_pulses, input read_position,
		input frame_start, output ready);
endinterface

interface mssp_cfg_if import mssp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/multiplexed_servo_pulse_sequencer_top.sv -----
// Top level of the multiplexed servo pulse sequencer: state, frame logic and
// result register. Depends on mssp_pkg and the interfaces in mssp_ifs.sv.
//
// Usage:
//  - item: one transaction per timer tick (mode 0) or per position update
//    (mode 1, stores a position byte and its pulse width for a channel).
//  - result: one transaction for every item, carrying the pulse bits, the
//    read-back position of the addressed channel and the frame start flag.
//  - cfg: register writes (0 frame_period, 1 channel_count), always ready;
//    write only while no item is in flight.
//  - A result appears in the cycle after its item is taken. Throughput is
//    one item per cycle unless result stalls; the whole step is a compare,
//    an 11-bit add and a width lookup between the state and result registers.
//  - While result is stalled, the held result stays put and item.ready stays
//    low; it rises again in the same cycle the receiver takes the result.
//  - Reset: frame_period 1250, no channels in use, all positions 128 (width
//    94), counter and pulse state cleared, no result pending.
`default_nettype none

module multiplexed_servo_pulse_sequencer_top import mssp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mssp_item_if.sink     item,
	mssp_result_if.source result,
	mssp_cfg_if.sink      cfg
);

	// Configuration registers
	logic [FRAME_W-1:0] frame_period_q;
	logic [CCNT_W-1:0]  channel_count_q;

	// Channel tables
	logic [POS_W-1:0]   positions_q    [CHANNELS];
	logic [WIDTH_W-1:0] pulse_widths_q [CHANNELS];

	// Frame sequencing state
	logic [FRAME_W-1:0] frame_count_q;
	logic [CH_W-1:0]    active_q;
	logic [FRAME_W-1:0] pulse_end_q;
	logic               pulse_on_q;

	// Result register
	logic               res_valid_q;
	logic [PULSE_W-1:0] res_pulses_q;
	logic [POS_W-1:0]   res_pos_q;
	logic               res_fs_q;

	// Next-state and result logic
	logic               accept;
	logic               ch_ok;
	logic [CH_W-1:0]    ch_idx;
	logic [CNT_W-1:0]   n_used;
	logic [CNT_W-1:0]   act_plus;
	logic               wrap;
	logic [FRAME_W-1:0] fc_inc;
	logic [WIDTH_W-1:0] new_width;
	logic [FRAME_W-1:0] frame_count_d;
	logic [CH_W-1:0]    active_d;
	logic [FRAME_W-1:0] pulse_end_d;
	logic               pulse_on_d;
	logic               fs_d;
	logic [PULSE_W-1:0] pulses_d;
	logic [POS_W-1:0]   rd_d;

	assign accept     = item.valid && item.ready;
	assign item.ready = !res_valid_q || result.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid          = res_valid_q;
	assign result.channel_pulses = res_pulses_q;
	assign result.read_position  = res_pos_q;
	assign result.frame_start    = res_fs_q;

	assign ch_ok     = CMP_W'(item.channel) < CMP_W'(CHANNELS);
	assign ch_idx    = CH_W'(item.channel);
	assign new_width = pulse_width(item.position);
	assign wrap      = frame_count_q >= frame_period_q;
	assign fc_inc    = frame_count_q + FRAME_W'(1);
	assign act_plus  = CNT_W'(active_q) + CNT_W'(1);

	// Clamp the channel count to what the tables hold.
	always_comb begin
		if (CMP_W'(channel_count_q) > CMP_W'(CHANNELS)) begin
			n_used = CNT_W'(CHANNELS);
		end else begin
			n_used = CNT_W'(channel_count_q);
		end
	end

	always_comb begin
		frame_count_d = frame_count_q;
		active_d      = active_q;
		pulse_end_d   = pulse_end_q;
		pulse_on_d    = pulse_on_q;
		fs_d          = 1'b0;
		if (item.mode == MODE_TICK) begin
			if (wrap) begin
				// Frame start: restart channel 0 if anything is in use.
				frame_count_d = '0;
				fs_d          = 1'b1;
				if (n_used != '0) begin
					active_d    = '0;
					pulse_end_d = FRAME_W'(pulse_widths_q[0]);
					pulse_on_d  = 1'b1;
				end else begin
					pulse_on_d = 1'b0;
				end
			end else begin
				frame_count_d = fc_inc;
				// End of the running pulse: hand over to the next channel or go quiet.
				if (pulse_on_q && fc_inc == pulse_end_q) begin
					if (act_plus < n_used) begin
						active_d    = CH_W'(act_plus);
						pulse_end_d = pulse_end_q
							+ FRAME_W'(pulse_widths_q[CH_W'(act_plus)]);
					end else begin
						pulse_on_d = 1'b0;
					end
				end
			end
		end
	end

	// Result fields reflect the state after this step.
	always_comb begin
		pulses_d = '0;
		if (pulse_on_d && CMP_W'(active_d) < CMP_W'(PULSE_W)) begin
			pulses_d = PULSE_W'(1) << active_d;
		end
		rd_d = '0;
		if (ch_ok) begin
			rd_d = (item.mode == MODE_SET) ? item.position : positions_q[ch_idx];
		end
	end

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q  <= FRAME_PERIOD_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_FRAME_PERIOD:  frame_period_q  <= FRAME_W'(cfg.data);
				REG_CHANNEL_COUNT: channel_count_q <= CCNT_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// Channel tables: update on a set transaction for a channel that exists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				positions_q[i]    <= POS_RST;
				pulse_widths_q[i] <= WIDTH_RST;
			end
		end else if (accept && item.mode == MODE_SET && ch_ok) begin
			positions_q[ch_idx]    <= item.position;
			pulse_widths_q[ch_idx] <= new_width;
		end
	end

	// Frame state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			active_q      <= '0;
			pulse_end_q   <= '0;
			pulse_on_q    <= 1'b0;
		end else if (accept) begin
			frame_count_q <= frame_count_d;
			active_q      <= active_d;
			pulse_end_q   <= pulse_end_d;
			pulse_on_q    <= pulse_on_d;
		end
	end

	// Result register: load on accept, drop once the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_pulses_q <= pulses_d;
			res_pos_q    <= rd_d;
			res_fs_q     <= fs_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mssp_checker.sv -----
// Port-level checker for the servo sequencer and its bind to the top level.
// Depends on mssp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mssp_checker import mssp_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_ready,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic [PULSE_W-1:0] channel_pulses,
	input wire logic [POS_W-1:0]   read_position,
	input wire logic               frame_start
);

	// A stalled result holds.
	`MSSP_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(channel_pulses) && $stable(read_position) && $stable(frame_start), "stalled result changed")

	// Every accepted item yields a result on the next cycle.
	`MSSP_ASSERT(a_item_to_result, clk, arst_n, item_valid && item_ready |=> result_valid, "accepted item gave no result")

	// Channels are pulsed one at a time.
	`MSSP_ASSERT(a_one_pulse, clk, arst_n, result_valid |-> $onehot0(channel_pulses), "more than one channel high")

	// A frame starts with channel 0 or with nothing.
	`MSSP_ASSERT(a_frame_ch0, clk, arst_n, result_valid && frame_start |-> channel_pulses == PULSE_W'(0) || channel_pulses == PULSE_W'(1), "frame start not on channel 0")

endmodule

bind multiplexed_servo_pulse_sequencer_top mssp_checker u_mssp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.channel_pulses (result.channel_pulses),
	.read_position  (result.read_position),
	.frame_start    (result.frame_start)
);

`default_nettype wire
